@@ hw/rtl/tkcb_pkg.sv @@
// ----------------------------------------------------------------------------
// tkcb_pkg
// Shared types, constants and the update microprogram for the candidate
// bank of two-coefficient Kalman regressions.
// ----------------------------------------------------------------------------
package tkcb_pkg;

    localparam int NUM_CANDS = 256;
    localparam int CAND_AW   = (NUM_CANDS > 1) ? $clog2(NUM_CANDS) : 1;
    localparam int QW        = 48;
    localparam int ROW_W     = 6 * QW;

    localparam logic CMD_LOAD = 1'b1;

    localparam logic signed [47:0] ONE_Q = 48'sd16777216;
    localparam logic signed [47:0] MAXV  = 48'sh7FFFFFFFFFFF;
    localparam logic signed [47:0] MINV  = 48'sh800000000000;
    localparam logic [50:0]        SIGN_MAG = 51'h800000000000;
    localparam logic [50:0]        MAX_MAG  = 51'h7FFFFFFFFFFF;
    localparam logic [24:0]        ONE_U25  = 25'd16777216;

    // one input item
    typedef struct packed {
        logic              cmd;
        logic [7:0]        cand;
        logic signed [47:0] y_obs;
        logic signed [47:0] sig_now;
        logic signed [47:0] sig_next;
        logic              sig_missing;
        logic [24:0]       forget_lambda;
        logic [24:0]       decay_kappa;
        logic              prior_slope_one;
        logic [46:0]       prior_var_icpt;
        logic [46:0]       prior_var_slope;
        logic [46:0]       prior_obs_var;
    } item_t;

    // one result item
    typedef struct packed {
        logic [7:0]        cand_out;
        logic signed [47:0] fc_mean;
        logic [46:0]       fc_var;
        logic              fc_valid;
    } result_t;

    // one row of the state memory
    typedef struct packed {
        logic signed [47:0] h;
        logic signed [47:0] css;
        logic signed [47:0] cis;
        logic signed [47:0] cii;
        logic signed [47:0] slope;
        logic signed [47:0] icpt;
    } row_t;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_MUL,
        OP_DIV
    } alu_op_t;

    typedef enum logic [4:0] {
        SRC_Y, SRC_S, SRC_SP, SRC_LAM, SRC_KAP,
        SRC_ICPT, SRC_SLOPE, SRC_CII, SRC_CIS, SRC_CSS, SRC_H,
        SRC_RII, SRC_RIS, SRC_RSS, SRC_E, SRC_G0, SRC_G1, SRC_TV,
        SRC_K0, SRC_K1, SRC_T0, SRC_T1, SRC_ONE, SRC_ZERO
    } src_t;

    typedef struct packed {
        alu_op_t op;
        src_t    a;
        src_t    b;
        src_t    c;
        logic    negb;
        logic    negc;
        src_t    dst;
    } step_t;

    typedef struct packed {
        logic    go;
        alu_op_t op;
        logic    negb;
        logic    negc;
    } alu_req_t;

    // working registers of one update
    typedef struct packed {
        logic signed [47:0] y;
        logic signed [47:0] s;
        logic signed [47:0] sp;
        logic signed [47:0] lam;
        logic signed [47:0] kap;
        logic signed [47:0] icpt;
        logic signed [47:0] slope;
        logic signed [47:0] cii;
        logic signed [47:0] cis;
        logic signed [47:0] css;
        logic signed [47:0] h;
        logic signed [47:0] rii;
        logic signed [47:0] ris;
        logic signed [47:0] rss;
        logic signed [47:0] e;
        logic signed [47:0] g0;
        logic signed [47:0] g1;
        logic signed [47:0] tv;
        logic signed [47:0] k0;
        logic signed [47:0] k1;
        logic signed [47:0] t0;
        logic signed [47:0] t1;
    } work_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_LATCH,
        S_ISSUE,
        S_WAIT,
        S_WB,
        S_OUT
    } top_st_t;

    typedef enum logic [1:0] {
        A_IDLE,
        A_MUL,
        A_DIV
    } alu_st_t;

    localparam int         PC_W      = 6;
    localparam logic [5:0] NUM_STEPS = 6'd39;
    localparam logic [5:0] WB_STEP   = 6'd28;
    localparam logic [5:0] DIV_STEPS = 6'd49;

    function automatic step_t mk(alu_op_t op, src_t a, src_t b, src_t c,
                                 logic nb, logic nc, src_t d);
        step_t st;
        st.op   = op;
        st.a    = a;
        st.b    = b;
        st.c    = c;
        st.negb = nb;
        st.negc = nc;
        st.dst  = d;
        return st;
    endfunction

    // update microprogram, one shared unit operation per step
    function automatic step_t prog(logic [5:0] pc);
        step_t st;
        case (pc)
            6'd0:  st = mk(OP_MUL, SRC_S,    SRC_SLOPE, SRC_ZERO, 1'b0, 1'b0, SRC_T0);
            6'd1:  st = mk(OP_ADD, SRC_Y,    SRC_ICPT,  SRC_T0,   1'b1, 1'b1, SRC_E);
            6'd2:  st = mk(OP_DIV, SRC_CII,  SRC_LAM,   SRC_ZERO, 1'b0, 1'b0, SRC_RII);
            6'd3:  st = mk(OP_DIV, SRC_CIS,  SRC_LAM,   SRC_ZERO, 1'b0, 1'b0, SRC_RIS);
            6'd4:  st = mk(OP_DIV, SRC_CSS,  SRC_LAM,   SRC_ZERO, 1'b0, 1'b0, SRC_RSS);
            6'd5:  st = mk(OP_MUL, SRC_E,    SRC_E,     SRC_ZERO, 1'b0, 1'b0, SRC_T0);
            6'd6:  st = mk(OP_ADD, SRC_ONE,  SRC_KAP,   SRC_ZERO, 1'b1, 1'b0, SRC_T1);
            6'd7:  st = mk(OP_MUL, SRC_T1,   SRC_T0,    SRC_ZERO, 1'b0, 1'b0, SRC_T0);
            6'd8:  st = mk(OP_MUL, SRC_KAP,  SRC_H,     SRC_ZERO, 1'b0, 1'b0, SRC_T1);
            6'd9:  st = mk(OP_ADD, SRC_T1,   SRC_T0,    SRC_ZERO, 1'b0, 1'b0, SRC_H);
            6'd10: st = mk(OP_MUL, SRC_S,    SRC_RIS,   SRC_ZERO, 1'b0, 1'b0, SRC_T0);
            6'd11: st = mk(OP_ADD, SRC_RII,  SRC_T0,    SRC_ZERO, 1'b0, 1'b0, SRC_G0);
            6'd12: st = mk(OP_MUL, SRC_S,    SRC_RSS,   SRC_ZERO, 1'b0, 1'b0, SRC_T0);
            6'd13: st = mk(OP_ADD, SRC_RIS,  SRC_T0,    SRC_ZERO, 1'b0, 1'b0, SRC_G1);
            6'd14: st = mk(OP_MUL, SRC_S,    SRC_G1,    SRC_ZERO, 1'b0, 1'b0, SRC_T0);
            6'd15: st = mk(OP_ADD, SRC_H,    SRC_G0,    SRC_T0,   1'b0, 1'b0, SRC_TV);
            6'd16: st = mk(OP_DIV, SRC_G0,   SRC_TV,    SRC_ZERO, 1'b0, 1'b0, SRC_K0);
            6'd17: st = mk(OP_DIV, SRC_G1,   SRC_TV,    SRC_ZERO, 1'b0, 1'b0, SRC_K1);
            6'd18: st = mk(OP_MUL, SRC_K0,   SRC_E,     SRC_ZERO, 1'b0, 1'b0, SRC_T0);
            6'd19: st = mk(OP_ADD, SRC_ICPT, SRC_T0,    SRC_ZERO, 1'b0, 1'b0, SRC_ICPT);
            6'd20: st = mk(OP_MUL, SRC_K1,   SRC_E,     SRC_ZERO, 1'b0, 1'b0, SRC_T0);
            6'd21: st = mk(OP_ADD, SRC_SLOPE, SRC_T0,   SRC_ZERO, 1'b0, 1'b0, SRC_SLOPE);
            6'd22: st = mk(OP_MUL, SRC_K0,   SRC_G0,    SRC_ZERO, 1'b0, 1'b0, SRC_T0);
            6'd23: st = mk(OP_ADD, SRC_RII,  SRC_T0,    SRC_ZERO, 1'b1, 1'b0, SRC_CII);
            6'd24: st = mk(OP_MUL, SRC_K0,   SRC_G1,    SRC_ZERO, 1'b0, 1'b0, SRC_T0);
            6'd25: st = mk(OP_ADD, SRC_RIS,  SRC_T0,    SRC_ZERO, 1'b1, 1'b0, SRC_CIS);
            6'd26: st = mk(OP_MUL, SRC_K1,   SRC_G1,    SRC_ZERO, 1'b0, 1'b0, SRC_T0);
            6'd27: st = mk(OP_ADD, SRC_RSS,  SRC_T0,    SRC_ZERO, 1'b1, 1'b0, SRC_CSS);
            6'd28: st = mk(OP_MUL, SRC_SP,   SRC_SLOPE, SRC_ZERO, 1'b0, 1'b0, SRC_T0);
            6'd29: st = mk(OP_ADD, SRC_ICPT, SRC_T0,    SRC_ZERO, 1'b0, 1'b0, SRC_E);
            6'd30: st = mk(OP_DIV, SRC_CII,  SRC_LAM,   SRC_ZERO, 1'b0, 1'b0, SRC_RII);
            6'd31: st = mk(OP_DIV, SRC_CIS,  SRC_LAM,   SRC_ZERO, 1'b0, 1'b0, SRC_RIS);
            6'd32: st = mk(OP_DIV, SRC_CSS,  SRC_LAM,   SRC_ZERO, 1'b0, 1'b0, SRC_RSS);
            6'd33: st = mk(OP_MUL, SRC_SP,   SRC_RIS,   SRC_ZERO, 1'b0, 1'b0, SRC_T0);
            6'd34: st = mk(OP_ADD, SRC_H,    SRC_RII,   SRC_T0,   1'b0, 1'b0, SRC_T1);
            6'd35: st = mk(OP_MUL, SRC_SP,   SRC_RSS,   SRC_ZERO, 1'b0, 1'b0, SRC_T0);
            6'd36: st = mk(OP_ADD, SRC_RIS,  SRC_T0,    SRC_ZERO, 1'b0, 1'b0, SRC_T0);
            6'd37: st = mk(OP_MUL, SRC_SP,   SRC_T0,    SRC_ZERO, 1'b0, 1'b0, SRC_T0);
            6'd38: st = mk(OP_ADD, SRC_T1,   SRC_T0,    SRC_ZERO, 1'b0, 1'b0, SRC_T1);
            default: st = mk(OP_ADD, SRC_ZERO, SRC_ZERO, SRC_ZERO, 1'b0, 1'b0, SRC_T0);
        endcase
        return st;
    endfunction

    // operand select from the working registers
    function automatic logic signed [47:0] pick(src_t s, work_t w);
        logic signed [47:0] v;
        case (s)
            SRC_Y:     v = w.y;
            SRC_S:     v = w.s;
            SRC_SP:    v = w.sp;
            SRC_LAM:   v = w.lam;
            SRC_KAP:   v = w.kap;
            SRC_ICPT:  v = w.icpt;
            SRC_SLOPE: v = w.slope;
            SRC_CII:   v = w.cii;
            SRC_CIS:   v = w.cis;
            SRC_CSS:   v = w.css;
            SRC_H:     v = w.h;
            SRC_RII:   v = w.rii;
            SRC_RIS:   v = w.ris;
            SRC_RSS:   v = w.rss;
            SRC_E:     v = w.e;
            SRC_G0:    v = w.g0;
            SRC_G1:    v = w.g1;
            SRC_TV:    v = w.tv;
            SRC_K0:    v = w.k0;
            SRC_K1:    v = w.k1;
            SRC_T0:    v = w.t0;
            SRC_T1:    v = w.t1;
            SRC_ONE:   v = ONE_Q;
            default:   v = '0;
        endcase
        return v;
    endfunction

    // magnitude and sign back to saturated two's complement
    function automatic logic signed [47:0] from_mag(logic [50:0] m, logic neg);
        logic signed [47:0] v;
        if (neg)
        begin
            if (m > SIGN_MAG)
                v = MINV;
            else
                v = $signed(48'(51'd0 - m));
        end
        else
        begin
            if (m > MAX_MAG)
                v = MAXV;
            else
                v = $signed(m[47:0]);
        end
        return v;
    endfunction

endpackage

@@ hw/rtl/tkcb_ram.sv @@
// ----------------------------------------------------------------------------
// tkcb_ram
// Generic single write port memory with registered read.
// ----------------------------------------------------------------------------
module tkcb_ram #(
    parameter int WIDTH = 288,
    parameter int DEPTH = 256
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

@@ hw/rtl/tkcb_alu.sv @@
// ----------------------------------------------------------------------------
// tkcb_alu
// Shared Q24.24 unit: saturating three-term add, four-pass 24x24 multiply,
// bit-serial restoring divide, the last two rounded half away from zero.
// ----------------------------------------------------------------------------
module tkcb_alu (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tkcb_pkg::alu_req_t    req,
    input  logic signed [47:0]    a,
    input  logic signed [47:0]    b,
    input  logic signed [47:0]    c,
    output logic                  done,
    output logic signed [47:0]    res
);

    localparam logic signed [49:0] SUM_MAX = 50'sd140737488355327;
    localparam logic signed [49:0] SUM_MIN = -50'sd140737488355328;

    tkcb_pkg::alu_st_t  st_reg, st_next;
    logic [1:0]         phase_reg, phase_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic               done_reg, done_next;
    logic [47:0]        ma_reg, ma_next;
    logic [47:0]        mb_reg, mb_next;
    logic               neg_reg, neg_next;
    logic [50:0]        acc_reg, acc_next;
    logic [47:0]        rem_reg, rem_next;
    logic [48:0]        sh_reg, sh_next;
    logic [48:0]        q_reg, q_next;
    logic signed [47:0] res_reg, res_next;

    logic [47:0]        mag_a, mag_b;
    logic signed [49:0] sa, sb, sc, sum;
    logic [23:0]        mx, my;
    logic [47:0]        prod;
    logic [48:0]        r2;
    logic               ge;
    logic [48:0]        qf;
    logic [49:0]        rnd;

    assign mag_a = a[47] ? 48'(48'd0 - a) : a;
    assign mag_b = b[47] ? 48'(48'd0 - b) : b;

    always_comb
    begin
        sa  = 50'(a);
        sb  = req.negb ? -50'(b) : 50'(b);
        sc  = req.negc ? -50'(c) : 50'(c);
        sum = sa + sb + sc;
    end

    // partial product of the magnitudes, low halves first
    always_comb
    begin
        case (phase_reg)
            2'd0:    begin mx = ma_reg[23:0];  my = mb_reg[23:0];  end
            2'd1:    begin mx = ma_reg[23:0];  my = mb_reg[47:24]; end
            2'd2:    begin mx = ma_reg[47:24]; my = mb_reg[23:0];  end
            default: begin mx = ma_reg[47:24]; my = mb_reg[47:24]; end
        endcase
        prod = mx * my;
    end

    assign r2  = {rem_reg, sh_reg[48]};
    assign ge  = (r2 >= {1'b0, mb_reg});
    assign qf  = {q_reg[47:0], ge};
    assign rnd = (50'(qf) + 50'd1) >> 1;

    always_comb
    begin
        st_next    = st_reg;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        sh_next    = sh_reg;
        q_next     = q_reg;
        res_next   = res_reg;
        case (st_reg)
            tkcb_pkg::A_IDLE:
            begin
                if (req.go)
                begin
                    ma_next  = mag_a;
                    mb_next  = mag_b;
                    neg_next = a[47] != b[47];
                    case (req.op)
                        tkcb_pkg::OP_MUL:
                        begin
                            phase_next = 2'd0;
                            st_next    = tkcb_pkg::A_MUL;
                        end
                        tkcb_pkg::OP_DIV:
                        begin
                            if (mag_b == 48'd0)
                            begin
                                res_next  = '0;
                                done_next = 1'b1;
                            end
                            else if ({24'd0, mag_a[47:24]} >= mag_b)
                            begin
                                res_next  = tkcb_pkg::from_mag(tkcb_pkg::SIGN_MAG,
                                                               a[47] != b[47]);
                                done_next = 1'b1;
                            end
                            else
                            begin
                                rem_next = {24'd0, mag_a[47:24]};
                                sh_next  = {mag_a[23:0], 25'd0};
                                q_next   = '0;
                                cnt_next = tkcb_pkg::DIV_STEPS;
                                st_next  = tkcb_pkg::A_DIV;
                            end
                        end
                        default:
                        begin
                            if (sum > SUM_MAX)
                                res_next = tkcb_pkg::MAXV;
                            else if (sum < SUM_MIN)
                                res_next = tkcb_pkg::MINV;
                            else
                                res_next = sum[47:0];
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            tkcb_pkg::A_MUL:
            begin
                phase_next = phase_reg + 2'd1;
                case (phase_reg)
                    2'd0:
                        acc_next = 51'((49'(prod) + 49'd8388608) >> 24);
                    2'd3:
                    begin
                        if (prod >= 48'd16777216)
                            res_next = tkcb_pkg::from_mag(tkcb_pkg::SIGN_MAG, neg_reg);
                        else
                            res_next = tkcb_pkg::from_mag(
                                acc_reg + 51'({prod[23:0], 24'd0}), neg_reg);
                        done_next = 1'b1;
                        st_next   = tkcb_pkg::A_IDLE;
                    end
                    default:
                        acc_next = acc_reg + 51'(prod);
                endcase
            end
            tkcb_pkg::A_DIV:
            begin
                rem_next = ge ? 48'(r2 - {1'b0, mb_reg}) : r2[47:0];
                sh_next  = {sh_reg[47:0], 1'b0};
                q_next   = qf;
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    res_next  = tkcb_pkg::from_mag(51'(rnd), neg_reg);
                    done_next = 1'b1;
                    st_next   = tkcb_pkg::A_IDLE;
                end
            end
            default:
                st_next = tkcb_pkg::A_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= tkcb_pkg::A_IDLE;
            phase_reg <= 2'd0;
            cnt_reg   <= 6'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            st_reg    <= st_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ma_reg  <= ma_next;
        mb_reg  <= mb_next;
        neg_reg <= neg_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        q_reg   <= q_next;
        res_reg <= res_next;
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

@@ hw/rtl/tvc_kalman_candidate_bank_core.sv @@
// ----------------------------------------------------------------------------
// tvc_kalman_candidate_bank_core
// Bank of two-coefficient Kalman regressions with forgetting factor; one
// shared Q24.24 unit runs a fixed microprogram for each update item.
// ----------------------------------------------------------------------------
//
//  channel   ports                     direction  handshake
//  --------  ------------------------  ---------  ----------------------------
//  item      start, busy, item         in         taken when start && !busy
//  result    done, result              out        one-cycle strobe on done
//
//  a load, a missing signal or an index beyond the bank gives its result in the
//  cycle after the item is taken; an update runs the eight bit-serial divisions
//  of the shared unit, sixteen four-pass multiplies and fifteen adds, each
//  sequenced one at a time
//  busy stays high for the whole update; the receiver cannot stall, so the
//  result register is simply overwritten by the next item
//  reset clears the sequencer; the state memory is undefined until loaded
//
module tvc_kalman_candidate_bank_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  tkcb_pkg::item_t   item,
    output logic              done,
    output tkcb_pkg::result_t result
);

    tkcb_pkg::top_st_t  st_reg, st_next;
    logic [5:0]         pc_reg, pc_next;
    logic [7:0]         cand_reg, cand_next;
    logic               done_reg, done_next;
    tkcb_pkg::result_t  result_reg, result_next;
    tkcb_pkg::work_t    work_reg, work_next;

    // state memory
    logic                          ram_we;
    logic [tkcb_pkg::CAND_AW-1:0]  ram_waddr;
    tkcb_pkg::row_t                ram_wdata;
    logic [tkcb_pkg::CAND_AW-1:0]  ram_raddr;
    logic [tkcb_pkg::ROW_W-1:0]    ram_rdata;
    tkcb_pkg::row_t                rd_row;
    tkcb_pkg::row_t                load_row;

    // shared unit
    tkcb_pkg::step_t    step;
    tkcb_pkg::alu_req_t alu_req;
    logic               alu_done;
    logic signed [47:0] alu_res;

    logic               accept;
    logic               in_range;
    logic [24:0]        lam_c;
    logic [24:0]        kap_c;

    assign accept   = start && (st_reg == tkcb_pkg::S_IDLE);
    assign in_range = ({24'd0, item.cand} < 32'(tkcb_pkg::NUM_CANDS));
    assign busy     = (st_reg != tkcb_pkg::S_IDLE);

    // lambda of zero acts as the smallest step, both factors cap at one
    always_comb
    begin
        if (item.forget_lambda == 25'd0)
            lam_c = 25'd1;
        else if (item.forget_lambda > tkcb_pkg::ONE_U25)
            lam_c = tkcb_pkg::ONE_U25;
        else
            lam_c = item.forget_lambda;
        kap_c = (item.decay_kappa > tkcb_pkg::ONE_U25) ? tkcb_pkg::ONE_U25
                                                       : item.decay_kappa;
    end

    // prior row written by a load item
    always_comb
    begin
        load_row.icpt  = '0;
        load_row.slope = item.prior_slope_one ? tkcb_pkg::ONE_Q : '0;
        load_row.cii   = $signed({1'b0, item.prior_var_icpt});
        load_row.cis   = '0;
        load_row.css   = $signed({1'b0, item.prior_var_slope});
        load_row.h     = $signed({1'b0, item.prior_obs_var});
    end

    assign rd_row = tkcb_pkg::row_t'(ram_rdata);

    // memory ports: loads write on accept, updates write back after the
    // last state step of the microprogram
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = tkcb_pkg::CAND_AW'(cand_reg);
        ram_wdata = load_row;
        if (accept && in_range && (item.cmd == tkcb_pkg::CMD_LOAD))
        begin
            ram_we    = 1'b1;
            ram_waddr = tkcb_pkg::CAND_AW'(item.cand);
        end
        else if (st_reg == tkcb_pkg::S_WB)
        begin
            ram_we          = 1'b1;
            ram_wdata.icpt  = work_reg.icpt;
            ram_wdata.slope = work_reg.slope;
            ram_wdata.cii   = work_reg.cii;
            ram_wdata.cis   = work_reg.cis;
            ram_wdata.css   = work_reg.css;
            ram_wdata.h     = work_reg.h;
        end
    end

    assign ram_raddr = tkcb_pkg::CAND_AW'(cand_reg);

    tkcb_ram #(
        .WIDTH (tkcb_pkg::ROW_W),
        .DEPTH (tkcb_pkg::NUM_CANDS)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // current microprogram step drives the shared unit
    assign step         = tkcb_pkg::prog(pc_reg);
    assign alu_req.go   = (st_reg == tkcb_pkg::S_ISSUE);
    assign alu_req.op   = step.op;
    assign alu_req.negb = step.negb;
    assign alu_req.negc = step.negc;

    tkcb_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .a     (tkcb_pkg::pick(step.a, work_reg)),
        .b     (tkcb_pkg::pick(step.b, work_reg)),
        .c     (tkcb_pkg::pick(step.c, work_reg)),
        .done  (alu_done),
        .res   (alu_res)
    );

    // sequencer
    always_comb
    begin
        st_next     = st_reg;
        pc_next     = pc_reg;
        cand_next   = cand_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        case (st_reg)
            tkcb_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    cand_next = item.cand;
                    pc_next   = '0;
                    if (in_range && (item.cmd != tkcb_pkg::CMD_LOAD) && !item.sig_missing)
                        st_next = tkcb_pkg::S_READ;
                    else
                    begin
                        // load, missing signal or out of bank: invalid result now
                        result_next.cand_out = item.cand;
                        result_next.fc_mean  = '0;
                        result_next.fc_var   = '0;
                        result_next.fc_valid = 1'b0;
                        done_next            = 1'b1;
                    end
                end
            end
            tkcb_pkg::S_READ:
                st_next = tkcb_pkg::S_LATCH;
            tkcb_pkg::S_LATCH:
                st_next = tkcb_pkg::S_ISSUE;
            tkcb_pkg::S_ISSUE:
                st_next = tkcb_pkg::S_WAIT;
            tkcb_pkg::S_WAIT:
            begin
                if (alu_done)
                begin
                    pc_next = pc_reg + 6'd1;
                    if (pc_reg == tkcb_pkg::WB_STEP - 6'd1)
                        st_next = tkcb_pkg::S_WB;
                    else if (pc_reg == tkcb_pkg::NUM_STEPS - 6'd1)
                        st_next = tkcb_pkg::S_OUT;
                    else
                        st_next = tkcb_pkg::S_ISSUE;
                end
            end
            tkcb_pkg::S_WB:
                st_next = tkcb_pkg::S_ISSUE;
            tkcb_pkg::S_OUT:
            begin
                // forecast mean sits in e, forecast variance in t1
                result_next.cand_out = cand_reg;
                result_next.fc_mean  = work_reg.e;
                result_next.fc_var   = work_reg.t1[47] ? 47'd0 : work_reg.t1[46:0];
                result_next.fc_valid = 1'b1;
                done_next            = 1'b1;
                st_next              = tkcb_pkg::S_IDLE;
            end
            default:
                st_next = tkcb_pkg::S_IDLE;
        endcase
    end

    // working registers: inputs on accept, state row after the read,
    // unit results at their destination
    always_comb
    begin
        work_next = work_reg;
        if (accept)
        begin
            work_next.y   = item.y_obs;
            work_next.s   = item.sig_now;
            work_next.sp  = item.sig_next;
            work_next.lam = $signed({23'd0, lam_c});
            work_next.kap = $signed({23'd0, kap_c});
        end
        if (st_reg == tkcb_pkg::S_LATCH)
        begin
            work_next.icpt  = rd_row.icpt;
            work_next.slope = rd_row.slope;
            work_next.cii   = rd_row.cii;
            work_next.cis   = rd_row.cis;
            work_next.css   = rd_row.css;
            work_next.h     = rd_row.h;
        end
        if ((st_reg == tkcb_pkg::S_WAIT) && alu_done)
        begin
            case (step.dst)
                tkcb_pkg::SRC_ICPT:  work_next.icpt  = alu_res;
                tkcb_pkg::SRC_SLOPE: work_next.slope = alu_res;
                tkcb_pkg::SRC_CII:   work_next.cii   = alu_res;
                tkcb_pkg::SRC_CIS:   work_next.cis   = alu_res;
                tkcb_pkg::SRC_CSS:   work_next.css   = alu_res;
                tkcb_pkg::SRC_H:     work_next.h     = alu_res;
                tkcb_pkg::SRC_RII:   work_next.rii   = alu_res;
                tkcb_pkg::SRC_RIS:   work_next.ris   = alu_res;
                tkcb_pkg::SRC_RSS:   work_next.rss   = alu_res;
                tkcb_pkg::SRC_E:     work_next.e     = alu_res;
                tkcb_pkg::SRC_G0:    work_next.g0    = alu_res;
                tkcb_pkg::SRC_G1:    work_next.g1    = alu_res;
                tkcb_pkg::SRC_TV:    work_next.tv    = alu_res;
                tkcb_pkg::SRC_K0:    work_next.k0    = alu_res;
                tkcb_pkg::SRC_K1:    work_next.k1    = alu_res;
                tkcb_pkg::SRC_T1:    work_next.t1    = alu_res;
                default:             work_next.t0    = alu_res;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= tkcb_pkg::S_IDLE;
            pc_reg   <= '0;
            cand_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            pc_reg   <= pc_next;
            cand_reg <= cand_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        work_reg   <= work_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // a taken item either finishes at once or keeps the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("item taken without result or busy");

    // a result only appears once the sequencer is back at rest
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // the state row is written only for a load or at write-back
    a_ram_write: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ((st_reg == tkcb_pkg::S_IDLE) || (st_reg == tkcb_pkg::S_WB)))
        else $error("state write outside load or write-back");

    // write-back happens exactly after the last state step
    a_wb_pc: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == tkcb_pkg::S_WB) |-> (pc_reg == tkcb_pkg::WB_STEP))
        else $error("write-back at wrong step");

    // the shared unit only reports back while the sequencer waits on it
    a_alu_done: assert property (@(posedge clk) disable iff (!rst_n)
        alu_done |-> (st_reg == tkcb_pkg::S_WAIT))
        else $error("unit result outside wait state");

endmodule
